// ===== src/nmec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmec_pkg
// Shared widths, codes and controller/datapath interface types for the NFA
// move / epsilon-closure engine.
// ----------------------------------------------------------------------------
package nmec_pkg;

  // field widths
  localparam int SET_W      = 10;  // NFA state-set bitmask
  localparam int STATE_W    = 4;   // state number
  localparam int SYM_W      = 4;   // alphabet symbol
  localparam int CMD_W      = 2;   // item kind
  localparam int ACT_W      = 4;   // active state count
  localparam int IDX_W      = $clog2(SET_W);

  // stream word layout
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;
  localparam int SRC_LSB     = 0;
  localparam int SYM_LSB     = SRC_LSB + STATE_W;
  localparam int TGT_LSB     = SYM_LSB + SYM_W;
  localparam int CUR_LSB     = TGT_LSB + SET_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SET_W;

  // parameter defaults
  localparam int STATES_DEF  = 10;
  localparam int SYMBOLS_DEF = 10;

  localparam logic [ACT_W-1:0] ACTIVE_RST = ACT_W'(10);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FINAL_MASK = 1'b0,
    CFG_ACTIVE     = 1'b1
  } cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the accepted word
    logic ld_close;    // accepted word is a closure-only query
    logic row_we;      // write the latched edge row
    logic clr_we;      // clearing pass write
    logic scan;        // issue / absorb table rows
    logic mode_close;  // scan follows epsilon rows
    logic seed;        // closure starts from the move result
    logic out_load;    // capture the result into the output register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic pend_empty;  // no row left to read
    logic clr_last;    // clearing pass at its last entry
  } sts_t;

endpackage
`default_nettype wire

// ===== src/nmec_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmec_ctrl
// Sequencer: clearing pass, item decode, row write, move scan, closure scan,
// result hand-off and output valid.
// ----------------------------------------------------------------------------
module nmec_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [nmec_pkg::CMD_W-1:0] in_cmd,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output nmec_pkg::ctl_t                ctl,
  input  wire nmec_pkg::sts_t           sts
);
  import nmec_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_MOVE,
    S_SEED,
    S_CLOSE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_we = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load     = 1'b1;
          ctl.ld_close = (in_cmd == CMD_CLOSE);
          case (in_cmd)
            CMD_WRITE: state_nxt = S_WRITE;
            CMD_MOVE:  state_nxt = S_MOVE;
            CMD_CLOSE: state_nxt = S_CLOSE;
            default:   state_nxt = S_FINISH;
          endcase
        end
      end
      S_WRITE: begin
        ctl.row_we = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_MOVE: begin
        ctl.scan = 1'b1;
        if (sts.pend_empty) state_nxt = S_SEED;
      end
      S_SEED: begin
        ctl.seed  = 1'b1;
        state_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        ctl.scan       = 1'b1;
        ctl.mode_close = 1'b1;
        if (sts.pend_empty) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_vld_r || out_tready) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

endmodule
`default_nettype wire

// ===== src/nmec_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmec_dp
// Datapath: edge table memory, configuration registers, worklist scan of
// table rows and the output register.
// ----------------------------------------------------------------------------
module nmec_dp #(
  parameter int STATES  = nmec_pkg::STATES_DEF,
  parameter int SYMBOLS = nmec_pkg::SYMBOLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire nmec_pkg::ctl_t                ctl,
  output nmec_pkg::sts_t                     sts,
  input  wire logic [nmec_pkg::STATE_W-1:0]  in_src,
  input  wire logic [nmec_pkg::SYM_W-1:0]    in_sym,
  input  wire logic [nmec_pkg::SET_W-1:0]    in_tgt,
  input  wire logic [nmec_pkg::SET_W-1:0]    in_cur,
  input  wire logic                          cfg_we,
  input  wire logic [nmec_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [nmec_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [nmec_pkg::SET_W-1:0]         out_set,
  output logic                               out_acc
);
  import nmec_pkg::*;

  localparam int DEPTH  = STATES * SYMBOLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration
  logic [SET_W-1:0] final_r;
  logic [ACT_W-1:0] active_r;

  // latched item
  logic [STATE_W-1:0] src_r;
  logic [SYM_W-1:0]   sym_r;
  logic [SET_W-1:0]   tgt_r;

  // scan state
  logic [SET_W-1:0]  pending_r, pending_nxt;
  logic [SET_W-1:0]  result_r, result_nxt;
  logic              rd_vld_r;
  logic [SET_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // output register
  logic [SET_W-1:0]  out_set_r;
  logic              out_acc_r;

  logic [SET_W-1:0]  mem [DEPTH];

  logic [SET_W-1:0]  live;
  logic [SET_W-1:0]  row_live;
  logic [SET_W-1:0]  new_bits;
  logic [SET_W-1:0]  pend_now;
  logic [SET_W-1:0]  pick;
  logic [IDX_W-1:0]  pick_idx;
  logic              issue;
  logic              in_sym_ok;
  logic              wr_ok;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [SET_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  // states below min(active_states, STATES) are live
  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      live[i] = (i < int'(active_r)) && (i < STATES);
    end
  end

  assign row_live = rd_vld_r ? (rd_data_r & live) : '0;
  assign new_bits = ctl.mode_close ? (row_live & ~result_r) : '0;
  assign pend_now = pending_r | new_bits;
  assign pick     = pend_now & (~pend_now + SET_W'(1));
  assign issue    = (pend_now != '0);

  always_comb begin
    pick_idx = '0;
    for (int i = SET_W - 1; i >= 0; i--) begin
      if (pend_now[i]) pick_idx = IDX_W'(i);
    end
  end

  assign pending_nxt = pend_now & ~pick;
  assign result_nxt  = result_r | row_live;

  assign in_sym_ok = (int'(in_sym) < SYMBOLS);
  assign wr_ok     = (int'(src_r) < STATES) && (int'(sym_r) < SYMBOLS);
  assign wr_addr   = ADDR_W'(int'(src_r) * SYMBOLS + int'(sym_r));
  assign rd_addr   = ADDR_W'(int'(pick_idx) * SYMBOLS +
                             (ctl.mode_close ? 0 : int'(sym_r)));

  assign mem_we    = ctl.clr_we || (ctl.row_we && wr_ok);
  assign mem_waddr = ctl.clr_we ? clr_cnt_r : wr_addr;
  assign mem_wdata = ctl.clr_we ? '0 : tgt_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  assign sts.pend_empty = !issue;
  assign sts.clr_last   = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_r   <= '0;
      active_r  <= ACTIVE_RST;
      rd_vld_r  <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FINAL_MASK: final_r  <= cfg_wdata;
          CFG_ACTIVE:     active_r <= cfg_wdata[ACT_W-1:0];
          default: ;
        endcase
      end
      rd_vld_r <= ctl.scan && issue;
      if (ctl.clr_we) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      src_r     <= in_src;
      sym_r     <= in_sym;
      tgt_r     <= in_tgt;
      pending_r <= (ctl.ld_close || in_sym_ok) ? (in_cur & live) : '0;
      result_r  <= ctl.ld_close ? (in_cur & live) : '0;
    end else if (ctl.scan) begin
      pending_r <= pending_nxt;
      result_r  <= result_nxt;
    end else if (ctl.seed) begin
      pending_r <= result_r;
    end
    if (ctl.out_load) begin
      out_set_r <= result_r;
      out_acc_r <= |(result_r & final_r);
    end
  end

  assign out_set = out_set_r;
  assign out_acc = out_acc_r;

endmodule
`default_nettype wire

// ===== src/nfa_move_epsilon_closure.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_move_epsilon_closure
// NFA edge table with move and epsilon-closure queries.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* stream: one word per item. in_tuser = command (write row, move then
//    closure, closure only). in_tdata holds src_state, symbol, target_mask,
//    current_set from bit 0 up.
//  - out_* stream: one word per item. out_tdata = next_set (zero for writes
//    and unknown commands), out_tuser = accepting.
//  - cfg_*: register writes (final_mask, active_states), always ready; write
//    only while no item is in flight.
//  - Processing: a move query reads the source rows, then the epsilon rows
//    of the closure; a closure query reads only the epsilon rows. The single
//    read port of the edge table reads one row per cycle. The block works on
//    one item at a time, and the next word can be taken in the cycle after
//    the result is handed to the output.
//  - Reset: all STATES*SYMBOLS table entries are cleared, one entry per
//    cycle; in_tready stays low meanwhile, config writes are still taken.
//  - A stalled receiver holds the output register; the block still takes
//    the next word and works on it, then waits to hand its result over.
// ----------------------------------------------------------------------------
module nfa_move_epsilon_closure #(
  parameter int STATES  = nmec_pkg::STATES_DEF,
  parameter int SYMBOLS = nmec_pkg::SYMBOLS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [3:0] src_state, [7:4] symbol, [17:8] target_mask, [27:18] current_set
  input  wire logic [nmec_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] cmd
  input  wire logic [nmec_pkg::CMD_W-1:0]        in_tuser,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [9:0] next_set
  output logic [nmec_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [0] accepting
  output logic                                   out_tuser,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nmec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nmec_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nmec_pkg::*;

  ctl_t             ctl;
  sts_t             sts;
  logic [SET_W-1:0] out_set;

  assign cfg_ready = 1'b1;

  // sequencer: owns the handshakes and walks the phases of an item
  nmec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .sts        (sts)
  );

  // table memory, row scan and result register
  nmec_dp #(
    .STATES  (STATES),
    .SYMBOLS (SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_src    (in_tdata[SRC_LSB +: STATE_W]),
    .in_sym    (in_tdata[SYM_LSB +: SYM_W]),
    .in_tgt    (in_tdata[TGT_LSB +: SET_W]),
    .in_cur    (in_tdata[CUR_LSB +: SET_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_set   (out_set),
    .out_acc   (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W - SET_W){1'b0}}, out_set};

`ifndef ASSERT_OFF
  // an accepting result must contain at least one state
  a_acc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser && (out_set == '0)))
    else $error("accepting flag with empty state set");

  // one item at a time: the port closes right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  // the table clearing pass keeps the input closed after reset
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during the clearing pass");
`endif

endmodule
`default_nettype wire

// ===== dv/nmec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmec_checker
// Watches the config, input and result streams of the NFA move / closure
// engine, keeps its own edge table and registers, predicts one result per
// accepted input word and compares every result word in order.
// ----------------------------------------------------------------------------
module nmec_checker #(
  parameter int STATES  = nmec_pkg::STATES_DEF,
  parameter int SYMBOLS = nmec_pkg::SYMBOLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [nmec_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [nmec_pkg::CMD_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [nmec_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [nmec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nmec_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import nmec_pkg::*;

  typedef struct packed {
    logic [SET_W-1:0] next_set;
    logic             accepting;
  } nfa_result_t;

  logic [SET_W-1:0] edge_rows [STATES*SYMBOLS];
  logic [SET_W-1:0] final_bits;
  logic [ACT_W-1:0] active_cnt;
  nfa_result_t      result_q [$];

  // states at or above the active count are dropped everywhere
  function automatic logic [SET_W-1:0] live_bits();
    int n;
    n = (active_cnt > STATES) ? STATES : int'(active_cnt);
    return SET_W'((1 << n) - 1);
  endfunction

  function automatic logic [SET_W-1:0] row_at(int st, int sym);
    if (st >= STATES || sym >= SYMBOLS) return '0;
    return edge_rows[st*SYMBOLS + sym];
  endfunction

  function automatic logic [SET_W-1:0] move_targets(logic [SET_W-1:0] set, int sym,
                                                    logic [SET_W-1:0] live);
    logic [SET_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < STATES; i++)
      if (set[i]) acc |= row_at(i, sym);
    return acc & live;
  endfunction

  // fixed point over epsilon rows, bounded by STATES rounds
  function automatic logic [SET_W-1:0] eps_closure(logic [SET_W-1:0] set,
                                                   logic [SET_W-1:0] live);
    logic [SET_W-1:0] cur;
    logic [SET_W-1:0] nxt;
    cur = set & live;
    for (int r = 0; r < STATES; r++) begin
      nxt = cur | move_targets(cur, 0, live);
      if (nxt == cur) break;
      cur = nxt;
    end
    return cur;
  endfunction

  function automatic nfa_result_t predict_closure(logic [CMD_W-1:0] cmd,
                                                  logic [IN_TDATA_W-1:0] word);
    logic [STATE_W-1:0] src;
    logic [SYM_W-1:0]   sym;
    logic [SET_W-1:0]   tgt;
    logic [SET_W-1:0]   cur;
    logic [SET_W-1:0]   live;
    nfa_result_t        res;
    src  = word[SRC_LSB +: STATE_W];
    sym  = word[SYM_LSB +: SYM_W];
    tgt  = word[TGT_LSB +: SET_W];
    cur  = word[CUR_LSB +: SET_W];
    live = live_bits();
    res  = '0;
    case (cmd)
      CMD_WRITE: begin
        if (src < STATES && sym < SYMBOLS)
          edge_rows[src*SYMBOLS + sym] = tgt & SET_W'((1 << STATES) - 1);
      end
      CMD_MOVE:  res.next_set = eps_closure(move_targets(cur & live, int'(sym), live),
                                            live);
      CMD_CLOSE: res.next_set = eps_closure(cur, live);
      default: ;  // unknown command: no effect, empty result
    endcase
    res.accepting = |(res.next_set & final_bits);
    return res;
  endfunction

  always @(posedge clk) begin
    nfa_result_t want;
    if (!rst_n) begin
      foreach (edge_rows[k]) edge_rows[k] = '0;
      final_bits = '0;
      active_cnt = ACTIVE_RST;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FINAL_MASK: final_bits = cfg_data[SET_W-1:0];
          CFG_ACTIVE:     active_cnt = cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      // the result leaving now belongs to an older word than one entering now
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing outstanding: next_set %0h accepting %0b",
                 out_tdata[SET_W-1:0], out_tuser);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_tdata[SET_W-1:0] !== want.next_set) begin
            $error("next_set mismatch: expected %0h, actual %0h",
                   want.next_set, out_tdata[SET_W-1:0]);
            fail_count++;
          end
          if (out_tuser !== want.accepting) begin
            $error("accepting mismatch: expected %0b, actual %0b",
                   want.accepting, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        result_q.insert(result_q.size(), predict_closure(in_tuser, in_tdata));
    end
    pending = result_q.size();
  end

endmodule

// ===== dv/tb_nfa_move_epsilon_closure.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfa_move_epsilon_closure
// Stimulus and verdict for the NFA move / epsilon-closure engine. A directed
// sequence loads a small NFA and hits the corner cases, then random blocks
// of edge writes and queries run under several config settings and idle /
// stall patterns. Checking is done by nmec_checker.
// ----------------------------------------------------------------------------
module tb_nfa_move_epsilon_closure;
  import nmec_pkg::*;

  localparam int CLK_HALF        = 6;
  // cycles with no word moving on any channel before the run is declared hung;
  // covers the table clearing pass after reset and long random stalls
  localparam int STALL_LIMIT     = 5000;
  // worst-case item latency plus margin
  localparam int DRAIN_CYCLES    = 2*STATES_DEF + 10;
  localparam int RANDOM_BLOCKS   = 8;
  localparam int ITEMS_PER_BLOCK = 250;
  // the one command code the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;
  localparam logic [SET_W-1:0] ALL_STATES = '1;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [3:0] src, [7:4] symbol, [17:8] target, [27:18] set
  logic [CMD_W-1:0]       in_tuser;   // [1:0] cmd
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [9:0] next_set
  logic                   out_tuser;  // [0] accepting
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count;
  int pending;
  int quiet_cycles   = 0;

  always #(CLK_HALF) clk = ~clk;

  nfa_move_epsilon_closure u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  nmec_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: one ready decision per cycle, made at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one input word. Called at a falling edge, returns at the falling
  // edge after acceptance with valid still high, so back-to-back words keep
  // valid asserted without a glitch.
  task automatic push_word(input logic [CMD_W-1:0] cmd, input logic [STATE_W-1:0] src,
                           input logic [SYM_W-1:0] sym, input logic [SET_W-1:0] tgt,
                           input logic [SET_W-1:0] cur);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[SRC_LSB +: STATE_W] = src;
    word[SYM_LSB +: SYM_W]   = sym;
    word[TGT_LSB +: SET_W]   = tgt;
    word[CUR_LSB +: SET_W]   = cur;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Both registers in one burst; valid stays high between the two words.
  task automatic set_config(input logic [SET_W-1:0] final_set, input logic [ACT_W-1:0] act);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FINAL_MASK;
    cfg_data  <= final_set;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_ACTIVE;
    cfg_data  <= CFG_DATA_W'(act);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SET_W-1:0] one_state();
    return SET_W'(1) << $urandom_range(0, SET_W-1);
  endfunction

  // Random item. Mostly well-formed: in-range rows, a small alphabet so moves
  // hit written rows, sparse targets so epsilon chains grow over several
  // rounds. A few out-of-range fields and unknown commands are mixed in.
  task automatic random_item();
    int                 pick;
    logic [CMD_W-1:0]   cmd;
    logic [STATE_W-1:0] src;
    logic [SYM_W-1:0]   sym;
    logic [SET_W-1:0]   tgt;
    logic [SET_W-1:0]   cur;
    pick = $urandom_range(0, 99);
    if (pick < 35)      cmd = CMD_WRITE;
    else if (pick < 65) cmd = CMD_MOVE;
    else if (pick < 95) cmd = CMD_CLOSE;
    else                cmd = CMD_RSVD;
    src = ($urandom_range(0, 19) == 0) ? STATE_W'($urandom_range(0, 15))
                                       : STATE_W'($urandom_range(0, STATES_DEF-1));
    pick = $urandom_range(0, 99);
    if (cmd == CMD_WRITE && pick < 40) sym = '0;            // epsilon rows
    else if (pick < 90)                sym = SYM_W'($urandom_range(0, 3));
    else                               sym = SYM_W'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       tgt = one_state();
      1:       tgt = one_state() | one_state();
      2:       tgt = '0;
      default: tgt = SET_W'($urandom_range(0, ALL_STATES));
    endcase
    cur = ($urandom_range(0, 1) == 0) ? one_state() : SET_W'($urandom_range(0, ALL_STATES));
    push_word(cmd, src, sym, tgt, cur);
  endtask

  initial begin
    logic [ACT_W-1:0] act_corner [4];
    logic [SET_W-1:0] fin;
    logic [ACT_W-1:0] act;
    act_corner = '{4'd0, 4'd15, 4'd3, 4'd1};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_WRITE;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_FINAL_MASK;
    cfg_data   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: small NFA with epsilon chain 0 -> 1 -> 2 -> 9, state 9
    // accepting. Config words are taken during the clearing pass.
    set_config(10'h200, 4'd10);
    push_word(CMD_WRITE, 4'd0, 4'd0, 10'h002, '0);
    push_word(CMD_WRITE, 4'd1, 4'd0, 10'h004, '0);
    push_word(CMD_WRITE, 4'd2, 4'd0, 10'h200, '0);
    push_word(CMD_WRITE, 4'd9, 4'd9, ALL_STATES, '0);        // top row, full targets
    push_word(CMD_WRITE, 4'd3, 4'd5, 10'h001, ALL_STATES);   // set field ignored
    push_word(CMD_WRITE, 4'hF, 4'd0, ALL_STATES, '0);        // source out of range
    push_word(CMD_WRITE, 4'd0, 4'hF, ALL_STATES, '0);        // symbol out of range
    push_word(CMD_CLOSE, 4'd0, 4'd0, '0, '0);                // empty set
    push_word(CMD_CLOSE, 4'd0, 4'd0, '0, 10'h001);           // full chain
    push_word(CMD_CLOSE, 4'hF, 4'hF, ALL_STATES, ALL_STATES);
    push_word(CMD_MOVE, 4'd0, 4'd5, '0, 10'h008);            // 3 -a-> 0, then chain
    push_word(CMD_MOVE, 4'd0, 4'd0, '0, ALL_STATES);         // move on epsilon
    push_word(CMD_MOVE, 4'd0, 4'd9, '0, 10'h200);
    push_word(CMD_MOVE, 4'd0, 4'hF, '0, ALL_STATES);         // symbol out of range
    push_word(CMD_MOVE, 4'd0, 4'd10, '0, ALL_STATES);        // first symbol past range
    push_word(CMD_RSVD, 4'hF, 4'hF, ALL_STATES, ALL_STATES); // unknown command
    push_word(CMD_WRITE, 4'd0, 4'd0, '0, '0);                // row replaced by empty
    push_word(CMD_CLOSE, 4'd0, 4'd0, '0, 10'h001);

    // Active count corners: none in use, above STATES, small.
    foreach (act_corner[i]) begin
      drain_results();
      set_config(ALL_STATES, act_corner[i]);
      push_word(CMD_CLOSE, 4'd0, 4'd0, '0, ALL_STATES);
      push_word(CMD_MOVE, 4'd0, 4'd9, '0, ALL_STATES);
    end

    // Random blocks, each with fresh registers and an idling pattern:
    // none, sender idle, receiver stalling, both lightly.
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      drain_results();
      case (b)
        0: begin
          fin = ALL_STATES;
          act = ACT_W'(STATES_DEF);
        end
        1: begin
          fin = '0;
          act = 4'd15;
        end
        default: begin
          fin = SET_W'($urandom_range(0, ALL_STATES));
          act = ($urandom_range(0, 2) == 0) ? ACT_W'($urandom_range(0, 15))
                                            : ACT_W'(STATES_DEF);
        end
      endcase
      set_config(fin, act);
      case (b % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (ITEMS_PER_BLOCK) random_item();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
